// ----- rtl/remf_pkg.sv -----
// ----------------------------------------------------------------------------
// remf_pkg: shared types and constants for region energy match fusion
// Frame limits, field widths, register indexes, controller states and the
// command / status structs between controller and datapath.
// ----------------------------------------------------------------------------
package remf_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int DIM_BITS   = 12;
   localparam int OWED_BITS  = 12;
   localparam int LIMIT_BITS = 16;
   localparam int IDX_BITS   = 2;
   localparam int PIX_BITS   = 8;
   localparam int SUM_BITS   = 20;
   localparam int PROD_BITS  = 40;
   localparam int DIV_BITS   = 41;
   localparam int Q_BITS     = 17;
   localparam int CNT_BITS   = 5;
   localparam int WIN_CELLS  = 9;
   localparam int K_BITS     = 4;
   localparam int MIN_DIM    = 5;

   localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [IDX_BITS-1:0] REG_MATCH_LIMIT  = 2'd2;

   localparam logic ACTION_FLUSH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FLUSH_RD,
      ST_SHIFT,
      ST_SUMS,
      ST_DECIDE,
      ST_MUL_DEN,
      ST_DIV1,
      ST_CHECK,
      ST_DIV2,
      ST_BLEND,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic flush_rd;
      logic shift;
      logic sum_step;
      logic set_avg;
      logic set_pick;
      logic mul_sq;
      logic div1_start;
      logic div2_start;
      logic div_step;
      logic blend;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic flush_ok;
      logic emit_due;
      logic sum_last;
      logic border;
      logic zero_sum;
      logic below_limit;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/remf_ram.sv -----
// ----------------------------------------------------------------------------
// remf_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module remf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/remf_dp.sv -----
// ----------------------------------------------------------------------------
// remf_dp: fusion datapath
// Config registers, line stores, 3x3 windows, window sums, shared
// restoring divider, blend and the output register.
// ----------------------------------------------------------------------------
module remf_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  remf_pkg::cmd_type             cmd,
   output remf_pkg::status_type          status,
   input  logic                          req_action,
   input  logic [remf_pkg::PIX_BITS-1:0] req_pixel_a,
   input  logic [remf_pkg::PIX_BITS-1:0] req_pixel_b,
   input  logic                          csr_valid,
   input  logic [remf_pkg::IDX_BITS-1:0] csr_index,
   input  logic [remf_pkg::LIMIT_BITS-1:0] csr_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [remf_pkg::PIX_BITS-1:0] rsp_fused_pixel,
   output logic                          rsp_last_of_frame
);
   import remf_pkg::*;

   localparam int PAIR_BITS = 2 * PIX_BITS;

   logic [DIM_BITS-1:0]   width_ff, height_ff;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic [COL_BITS-1:0]   in_col_ff, out_col_ff;
   logic [ROW_BITS-1:0]   in_row_ff, out_row_ff;
   logic [OWED_BITS-1:0]  owed_ff;
   logic [PIX_BITS-1:0]   new_a_ff, new_b_ff;
   logic                  top_sel_ff;
   logic [PIX_BITS-1:0]   win_a_ff [WIN_CELLS];
   logic [PIX_BITS-1:0]   win_b_ff [WIN_CELLS];
   logic [SUM_BITS-1:0]   sa_ff, sb_ff, sab_ff;
   logic [K_BITS-1:0]     k_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [DIV_BITS-1:0]   rem_ff, dd_ff;
   logic [Q_BITS-1:0]     q_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [PIX_BITS-1:0]   res_ff;
   logic                  rsp_valid_ff;
   logic [PIX_BITS-1:0]   rsp_pixel_ff;
   logic                  rsp_last_ff;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] r;
      r = v;
      if (v < DIM_BITS'(MIN_DIM)) r = DIM_BITS'(MIN_DIM);
      if (v > hi) r = hi;
      return r;
   endfunction

   // line stores, each entry holds the a/b pair
   logic [PAIR_BITS-1:0]  top_rd, mid_rd;
   logic [COL_BITS-1:0]   rd_addr;
   logic [DIM_BITS-1:0]   flush_col;

   assign flush_col = (owed_ff > width_ff) ? (width_ff - 1'b1) : (width_ff - owed_ff);
   assign rd_addr   = (req_action == ACTION_FLUSH) ? flush_col[COL_BITS-1:0] : in_col_ff;

   remf_ram #(.WIDTH(PAIR_BITS), .DEPTH(MAX_WIDTH)) u_ram_top (
      .clock   (clock),
      .wr_en   (cmd.shift),
      .wr_addr (in_col_ff),
      .wr_data (mid_rd),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (top_rd)
   );

   remf_ram #(.WIDTH(PAIR_BITS), .DEPTH(MAX_WIDTH)) u_ram_mid (
      .clock   (clock),
      .wr_en   (cmd.shift),
      .wr_addr (in_col_ff),
      .wr_data ({new_a_ff, new_b_ff}),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (mid_rd)
   );

   // combinational helpers
   logic [PAIR_BITS-1:0]  flush_pair;
   logic [PIX_BITS:0]     flush_sum, ctr_sum;
   logic [PIX_BITS-1:0]   ca, cb, pa, pb, pick_val, hi, lo, diff;
   logic [PIX_BITS-1:0]   blend_val;
   logic [LIMIT_BITS-1:0] w16;
   logic [Q_BITS-1:0]     w17;
   logic [PIX_BITS+LIMIT_BITS-1:0] blend_prod, blend_full;
   logic [DIV_BITS-1:0]   rem_sh;
   logic                  q_bit;
   logic [DIM_BITS-1:0]   r_ext, c_ext, in_col_nx, in_row_nx, out_col_nx, out_row_nx;
   logic                  interior;
   logic [PAIR_BITS-1:0]  sq_a, sq_b, sq_ab;
   logic [PROD_BITS-1:0]  den_prod;

   assign flush_pair = top_sel_ff ? top_rd : mid_rd;
   assign flush_sum  = {1'b0, flush_pair[PAIR_BITS-1:PIX_BITS]} +
                       {1'b0, flush_pair[PIX_BITS-1:0]};
   assign ca         = win_a_ff[4];
   assign cb         = win_b_ff[4];
   assign ctr_sum    = {1'b0, ca} + {1'b0, cb};
   assign pa         = win_a_ff[k_ff];
   assign pb         = win_b_ff[k_ff];
   assign sq_a       = pa * pa;
   assign sq_b       = pb * pb;
   assign sq_ab      = pa * pb;
   assign den_prod   = sa_ff * sb_ff;

   always_comb begin
      priority if (sa_ff == sb_ff) begin
         pick_val = ctr_sum[PIX_BITS:1];
      end else if (sa_ff > sb_ff) begin
         pick_val = ca;
      end else begin
         pick_val = cb;
      end
   end

   // blend: lo*w + hi*(1-w) = hi - (hi-lo)*w
   assign hi         = (ca < cb) ? cb : ca;
   assign lo         = (ca < cb) ? ca : cb;
   assign diff       = hi - lo;
   assign w17        = (Q_BITS'(1) << LIMIT_BITS) - q_ff;
   assign w16        = w17[Q_BITS-1:1];
   assign blend_prod = diff * w16;
   assign blend_full = {hi, {LIMIT_BITS{1'b0}}} - blend_prod;
   assign blend_val  = blend_full[PIX_BITS+LIMIT_BITS-1:LIMIT_BITS];

   // restoring divider, first step compares without shifting
   assign rem_sh = (cnt_ff == CNT_BITS'(Q_BITS)) ? rem_ff : {rem_ff[DIV_BITS-2:0], 1'b0};
   assign q_bit  = (rem_sh >= dd_ff);

   assign r_ext      = DIM_BITS'(out_row_ff);
   assign c_ext      = DIM_BITS'(out_col_ff);
   assign interior   = (r_ext > 1) && (r_ext + 2 < height_ff) &&
                       (c_ext > 1) && (c_ext + 2 < width_ff);
   assign in_col_nx  = DIM_BITS'(in_col_ff) + 1'b1;
   assign in_row_nx  = DIM_BITS'(in_row_ff) + 1'b1;
   assign out_col_nx = c_ext + 1'b1;
   assign out_row_nx = r_ext + 1'b1;

   always_comb begin
      status.flush_ok    = (in_col_ff == '0) && (in_row_ff == '0) && (owed_ff != '0);
      status.emit_due    = (owed_ff > width_ff);
      status.sum_last    = (k_ff == K_BITS'(WIN_CELLS - 1));
      status.border      = !interior;
      status.zero_sum    = (sa_ff == '0) || (sb_ff == '0);
      status.below_limit = (q_ff < {1'b0, limit_ff});
      status.div_done    = (cnt_ff == '0);
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         new_a_ff   <= req_pixel_a;
         new_b_ff   <= req_pixel_b;
         top_sel_ff <= (owed_ff > width_ff);
      end
      if (cmd.flush_rd) res_ff <= flush_sum[PIX_BITS:1];
      if (cmd.set_avg)  res_ff <= ctr_sum[PIX_BITS:1];
      if (cmd.set_pick) res_ff <= pick_val;
      if (cmd.blend)    res_ff <= blend_val;
      if (cmd.shift) begin
         sa_ff  <= '0;
         sb_ff  <= '0;
         sab_ff <= '0;
      end
      if (cmd.sum_step) begin
         sa_ff  <= sa_ff  + SUM_BITS'(sq_a);
         sb_ff  <= sb_ff  + SUM_BITS'(sq_b);
         sab_ff <= sab_ff + SUM_BITS'(sq_ab);
      end
      if (cmd.mul_sq) prod_ff <= sab_ff * sab_ff;
      if (cmd.div1_start) begin
         rem_ff <= DIV_BITS'(prod_ff);
         dd_ff  <= DIV_BITS'(den_prod);
         q_ff   <= '0;
      end
      if (cmd.div2_start) begin
         rem_ff <= DIV_BITS'((Q_BITS'(1) << LIMIT_BITS) - q_ff);
         dd_ff  <= DIV_BITS'((Q_BITS'(1) << LIMIT_BITS) - {1'b0, limit_ff});
         q_ff   <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= q_bit ? (rem_sh - dd_ff) : rem_sh;
         q_ff   <= {q_ff[Q_BITS-2:0], q_bit};
      end
      if (cmd.emit && status.out_free) begin
         rsp_pixel_ff <= res_ff;
         rsp_last_ff  <= (out_row_nx == height_ff) && (out_col_nx == width_ff);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DIM_BITS'(MAX_WIDTH);
         height_ff    <= DIM_BITS'(MAX_HEIGHT);
         limit_ff     <= LIMIT_BITS'(40501);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         owed_ff      <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WIN_CELLS; i++) begin
            win_a_ff[i] <= '0;
            win_b_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
               win_a_ff[r*3]   <= win_a_ff[r*3+1];
               win_a_ff[r*3+1] <= win_a_ff[r*3+2];
               win_b_ff[r*3]   <= win_b_ff[r*3+1];
               win_b_ff[r*3+1] <= win_b_ff[r*3+2];
            end
            win_a_ff[2] <= top_rd[PAIR_BITS-1:PIX_BITS];
            win_b_ff[2] <= top_rd[PIX_BITS-1:0];
            win_a_ff[5] <= mid_rd[PAIR_BITS-1:PIX_BITS];
            win_b_ff[5] <= mid_rd[PIX_BITS-1:0];
            win_a_ff[8] <= new_a_ff;
            win_b_ff[8] <= new_b_ff;
            if (in_col_nx >= width_ff) begin
               in_col_ff <= '0;
               in_row_ff <= (in_row_nx >= height_ff) ? '0 : in_row_nx[ROW_BITS-1:0];
            end else begin
               in_col_ff <= in_col_nx[COL_BITS-1:0];
            end
            owed_ff <= owed_ff + 1'b1;
            k_ff    <= '0;
         end
         if (cmd.sum_step)   k_ff   <= k_ff + 1'b1;
         if (cmd.div1_start || cmd.div2_start) cnt_ff <= CNT_BITS'(Q_BITS);
         if (cmd.div_step)   cnt_ff <= cnt_ff - 1'b1;
         if (cmd.emit && status.out_free) begin
            rsp_valid_ff <= 1'b1;
            owed_ff      <= owed_ff - 1'b1;
            if (out_col_nx >= width_ff) begin
               out_col_ff <= '0;
               out_row_ff <= (out_row_nx >= height_ff) ? '0 : out_row_nx[ROW_BITS-1:0];
            end else begin
               out_col_ff <= out_col_nx[COL_BITS-1:0];
            end
         end
         if (csr_valid) begin
            unique case (csr_index)
               REG_FRAME_WIDTH: begin
                  width_ff <= clamp_dim(csr_data[DIM_BITS-1:0], DIM_BITS'(MAX_WIDTH));
               end
               REG_FRAME_HEIGHT: begin
                  height_ff <= clamp_dim(csr_data[DIM_BITS-1:0], DIM_BITS'(MAX_HEIGHT));
               end
               REG_MATCH_LIMIT: begin
                  limit_ff <= csr_data;
               end
               default: begin
               end
            endcase
            // a size write restarts the stream
            if (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT) begin
               in_col_ff  <= '0;
               in_row_ff  <= '0;
               out_col_ff <= '0;
               out_row_ff <= '0;
               owed_ff    <= '0;
            end
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fused_pixel   = rsp_pixel_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

// ----- rtl/remf_ctrl.sv -----
// ----------------------------------------------------------------------------
// remf_ctrl: fusion sequencer
// Walks one beat through line store read, window shift, sums, divides
// and blend, and hands the result to the output register.
// ----------------------------------------------------------------------------
module remf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   input  remf_pkg::status_type status,
   output remf_pkg::cmd_type    cmd
);
   import remf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_action != ACTION_FLUSH) begin
                  state_in = ST_SHIFT;
               end else if (status.flush_ok) begin
                  state_in = ST_FLUSH_RD;
               end
            end
         end
         ST_FLUSH_RD: begin
            cmd.flush_rd = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = status.emit_due ? ST_SUMS : ST_IDLE;
         end
         ST_SUMS: begin
            cmd.sum_step = 1'b1;
            if (status.sum_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (status.border) begin
               cmd.set_avg = 1'b1;
               state_in    = ST_EMIT;
            end else if (status.zero_sum) begin
               cmd.set_pick = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               cmd.mul_sq = 1'b1;
               state_in   = ST_MUL_DEN;
            end
         end
         ST_MUL_DEN: begin
            cmd.div1_start = 1'b1;
            state_in       = ST_DIV1;
         end
         ST_DIV1: begin
            if (status.div_done) begin
               state_in = ST_CHECK;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_CHECK: begin
            if (status.below_limit) begin
               cmd.set_pick = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               cmd.div2_start = 1'b1;
               state_in       = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (status.div_done) begin
               state_in = ST_BLEND;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/region_energy_match_fusion.sv -----
// Path: a beat that owes no result frees the input after ST_SHIFT; a flush result loads
// the output register via ST_FLUSH_RD and ST_EMIT, a border or zero-energy pixel via
// ST_SHIFT, ST_SUMS, ST_DECIDE, ST_EMIT; a low-match interior pick adds ST_MUL_DEN, ST_DIV1,
// ST_CHECK; a blend adds ST_DIV2, ST_BLEND. Flow: one beat at a time, next accept the cycle
// after the result is loaded; a 9-step sum, then up to two 17-step divides on one divider.
// Reset: synchronous, clears counters, windows and config to defaults; line stores are not.
// ----------------------------------------------------------------------------
// region_energy_match_fusion: 3x3 region energy match fusion of two images
// Streams pixel pairs in raster order, one fused pixel per position.
// ----------------------------------------------------------------------------
module region_energy_match_fusion (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [remf_pkg::PIX_BITS-1:0]   req_pixel_a,
   input  logic [remf_pkg::PIX_BITS-1:0]   req_pixel_b,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [remf_pkg::PIX_BITS-1:0]   rsp_fused_pixel,
   output logic                            rsp_last_of_frame,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [remf_pkg::IDX_BITS-1:0]   csr_index,
   input  logic [remf_pkg::LIMIT_BITS-1:0] csr_data
);
   import remf_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   remf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   remf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_pixel_a       (req_pixel_a),
      .req_pixel_b       (req_pixel_b),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_fused_pixel   (rsp_fused_pixel),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
